/* rtl/ofifo_pkg.sv */
// ============================================================================
// ofifo_pkg
// Shared types, constants and helpers for the overwrite ring FIFO.
// ============================================================================
package ofifo_pkg;

    // Ring depth in packages. The fill count field is sized from it.
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_head_byte;
        logic [7:0] in_cyclic_code;
        logic [7:0] in_data_msb;
        logic [7:0] in_data_lsb;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       out_head_byte;
        logic [7:0]       out_cyclic_code;
        logic [7:0]       out_data_msb;
        logic [7:0]       out_data_lsb;
        logic             overwrote;
        logic             was_empty;
        logic [CNT_W-1:0] fill_count;
    } t_out_beat;

    // Result info carried from the control stage to the output register
    typedef struct packed {
        logic             has_data;
        logic             overwrote;
        logic             was_empty;
        logic [CNT_W-1:0] fill_count;
    } t_res_meta;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] last;
        last = PTR_W'(DEPTH - 1);
        return (p == last) ? '0 : p + 1'b1;
    endfunction

endpackage

/* rtl/ofifo_ram.sv */
// ============================================================================
// ofifo_ram
// Single-port-write, single-port-read package store, registered read data.
// ============================================================================
module ofifo_ram import ofifo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [PTR_W-1:0]  i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [PTR_W-1:0]  i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ofifo_ctrl.sv */
// ============================================================================
// ofifo_ctrl
// Pointer and count keeper; issues store accesses and stages result info.
// ============================================================================
module ofifo_ctrl import ofifo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_pkt,
    input  logic              i_res_take,
    output logic              o_res_valid,
    output t_res_meta         o_res_meta,
    output logic              o_we,
    output logic [PTR_W-1:0]  o_waddr,
    output logic [WORD_W-1:0] o_wdata,
    output logic              o_re,
    output logic [PTR_W-1:0]  o_raddr
);

    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_res_valid, n_res_valid;
    t_res_meta        r_meta, n_meta;
    logic             accept;
    logic             full;

    assign o_in_stall = r_res_valid && !i_res_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(DEPTH));

    assign o_waddr = r_wptr;
    assign o_raddr = r_rptr;
    assign o_wdata = {i_in_pkt.in_head_byte, i_in_pkt.in_cyclic_code,
                      i_in_pkt.in_data_msb, i_in_pkt.in_data_lsb};

    always_comb begin
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_count     = r_count;
        n_meta      = r_meta;
        n_res_valid = r_res_valid && !i_res_take;
        o_we        = 1'b0;
        o_re        = 1'b0;
        if (accept) begin
            n_res_valid    = 1'b1;
            n_meta         = '0;
            case (i_in_pkt.cmd)
                CMD_WRITE: begin
                    o_we   = 1'b1;
                    n_wptr = next_ptr(r_wptr);
                    if (full) begin
                        n_rptr           = next_ptr(r_rptr);
                        n_meta.overwrote = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_READ: begin
                    if (r_count == '0) begin
                        n_meta.was_empty = 1'b1;
                    end else begin
                        o_re            = 1'b1;
                        n_meta.has_data = 1'b1;
                        n_rptr          = next_ptr(r_rptr);
                        n_count         = r_count - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    n_wptr  = '0;
                    n_rptr  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
            n_meta.fill_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta <= n_meta;
    end

    assign o_res_valid = r_res_valid;
    assign o_res_meta  = r_meta;

endmodule

/* rtl/overwrite_ring_fifo_unit.sv */
// ============================================================================
// overwrite_ring_fifo_unit
// Ring FIFO of four-byte sample packages that drops the oldest when full.
// ============================================================================
//
//   channel  | direction | payload     | handshake
//   ---------+-----------+-------------+-------------------------
//   input    | in        | t_in_beat   | i_in_valid / o_in_stall
//   output   | out       | t_out_beat  | o_out_valid / i_out_stall
//
// Each input beat yields exactly one output beat. After it is taken it passes
// through the store access and staging slot in ofifo_ctrl, then the output
// register. A new beat is taken every cycle while the staged result can move
// on; the single staging slot plus the output register set that figure.
// Reset clears pointers, count and valids; the store itself is not cleared.
// Output stall backs up into the staging slot and then into o_in_stall.
//
module overwrite_ring_fifo_unit import ofifo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_pkt,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_pkt
);

    logic              res_valid;
    logic              res_take;
    t_res_meta         res_meta;
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  waddr;
    logic [PTR_W-1:0]  raddr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;

    logic              r_out_valid;
    t_out_beat         r_out_pkt, n_out_pkt;

    ofifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_pkt    (i_in_pkt),
        .i_res_take  (res_take),
        .o_res_valid (res_valid),
        .o_res_meta  (res_meta),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr)
    );

    ofifo_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Staged result moves when the output register is empty or draining
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    // Read data is held by the RAM until the next read, so a stalled
    // staging slot still sees the right word.
    always_comb begin
        n_out_pkt                 = r_out_pkt;
        if (res_take) begin
            if (res_meta.has_data) begin
                n_out_pkt.out_head_byte   = rdata[31:24];
                n_out_pkt.out_cyclic_code = rdata[23:16];
                n_out_pkt.out_data_msb    = rdata[15:8];
                n_out_pkt.out_data_lsb    = rdata[7:0];
            end else begin
                n_out_pkt.out_head_byte   = EMPTY_BYTE;
                n_out_pkt.out_cyclic_code = EMPTY_BYTE;
                n_out_pkt.out_data_msb    = EMPTY_BYTE;
                n_out_pkt.out_data_lsb    = EMPTY_BYTE;
            end
            n_out_pkt.overwrote  = res_meta.overwrote;
            n_out_pkt.was_empty  = res_meta.was_empty;
            n_out_pkt.fill_count = res_meta.fill_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pkt <= n_out_pkt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pkt   = r_out_pkt;

endmodule
